// ===== rtl/two_axis_dda_step_generator_defines.svh =====
// Assertion macros shared by the step generator RTL.
`ifndef TWO_AXIS_DDA_STEP_GENERATOR_DEFINES_SVH
`define TWO_AXIS_DDA_STEP_GENERATOR_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define DDA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define DDA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// ===== rtl/dda_pkg.sv =====
// Shared types and constants of the two-axis DDA step generator.
`timescale 1ns / 1ps
`default_nettype none
package dda_pkg;

  localparam int STEP_BITS  = 16;
  localparam int TIMER_BITS = 16;
  localparam int ACC_BITS   = STEP_BITS + 1;
  localparam int PEAK_BITS  = STEP_BITS - 1;

  // Input opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_START,
    KIND_CLEAR,
    KIND_NOP
  } dda_kind_e;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [STEP_BITS-1:0]  steps_x;
    logic signed [STEP_BITS-1:0]  steps_y;
    logic [TIMER_BITS-1:0]        phase_delay;
    logic                         clear_error;
    logic                         track_relative;
  } dda_in_t;

  typedef struct packed {
    logic                         step_x;
    logic                         step_y;
    logic                         dir_x;
    logic                         dir_y;
    logic                         busy_res;
    logic                         done_res;
    logic signed [STEP_BITS-1:0]  abs_x;
    logic signed [STEP_BITS-1:0]  rel_x;
    logic signed [STEP_BITS-1:0]  rel_y;
    logic [PEAK_BITS-1:0]         max_rel_x;
  } dda_out_t;

  // Decoded command carried from the front end to the executor
  typedef struct packed {
    dda_kind_e              kind;
    logic [STEP_BITS-1:0]   count_x;
    logic [STEP_BITS-1:0]   count_y;
    logic [STEP_BITS-1:0]   major;
    logic                   neg_x;
    logic                   neg_y;
    logic [TIMER_BITS-1:0]  delay;
    logic                   clear_error;
    logic                   track_relative;
  } dda_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/dda_front.sv =====
// Front end: accepts input transactions and decodes them into commands.
`timescale 1ns / 1ps
`default_nettype none
module dda_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  dda_pkg::dda_in_t in_item_i,
  output logic             push_valid_o,
  input  wire              push_stall_i,
  output dda_pkg::dda_cmd_t push_cmd_o
);
  import dda_pkg::*;

  logic [STEP_BITS-1:0] mag_x;
  logic [STEP_BITS-1:0] mag_y;
  logic                 held_q, held_d;

  // Magnitude of a two's complement count; the most negative value maps to 2^15
  function automatic logic [STEP_BITS-1:0] mag(input logic [STEP_BITS-1:0] raw);
    logic [STEP_BITS-1:0] v;
    v = raw;
    if (raw[STEP_BITS-1]) begin
      v = ~raw + {{(STEP_BITS-1){1'b0}}, 1'b1};
    end
    return v;
  endfunction

  assign in_stall_o   = push_stall_i;
  assign push_valid_o = in_valid_i;

  // Decode opcode and precompute move geometry
  always_comb begin
    mag_x = mag(in_item_i.steps_x);
    mag_y = mag(in_item_i.steps_y);
    case (in_item_i.op)
      OP_TICK:  push_cmd_o.kind = KIND_TICK;
      OP_START: push_cmd_o.kind = KIND_START;
      OP_CLEAR: push_cmd_o.kind = KIND_CLEAR;
      default:  push_cmd_o.kind = KIND_NOP;
    endcase
    push_cmd_o.count_x        = mag_x;
    push_cmd_o.count_y        = mag_y;
    push_cmd_o.major          = (mag_x > mag_y) ? mag_x : mag_y;
    push_cmd_o.neg_x          = in_item_i.steps_x[STEP_BITS-1];
    push_cmd_o.neg_y          = in_item_i.steps_y[STEP_BITS-1];
    push_cmd_o.delay          = in_item_i.phase_delay;
    push_cmd_o.clear_error    = in_item_i.clear_error;
    push_cmd_o.track_relative = in_item_i.track_relative;
  end

  // Track whether the last transaction was held off, for the stall check
  assign held_d = in_valid_i && push_stall_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else begin
      held_q <= held_d;
    end
  end

`include "two_axis_dda_step_generator_defines.svh"

  `DDA_ASSERT(a_front_hold_valid, clk_i, rst_ni, held_q |-> in_valid_i, "sender dropped a stalled transaction")

endmodule
`default_nettype wire

// ===== rtl/dda_queue.sv =====
// Two-entry command queue between the front end and the executor.
`timescale 1ns / 1ps
`default_nettype none
module dda_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_valid_i,
  output logic              push_stall_o,
  input  dda_pkg::dda_cmd_t push_cmd_i,
  output logic              pop_valid_o,
  input  wire               pop_stall_i,
  output dda_pkg::dda_cmd_t pop_cmd_o
);
  import dda_pkg::*;

  dda_cmd_t   slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_stall_o = (cnt_q == 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed command
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

`include "two_axis_dda_step_generator_defines.svh"

  `DDA_ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, cnt_q == 2'd3, "queue occupancy out of range")
  `DDA_ASSERT(a_queue_ptr_gap, clk_i, rst_ni, (cnt_q == 2'd1) |-> (wr_q != rd_q), "queue pointers disagree with occupancy")

endmodule
`default_nettype wire

// ===== rtl/dda_back.sv =====
// Executor: runs the DDA timer, pulse phases and position counters.
`timescale 1ns / 1ps
`default_nettype none
module dda_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               pop_valid_i,
  output logic              pop_stall_o,
  input  dda_pkg::dda_cmd_t pop_cmd_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output dda_pkg::dda_out_t out_item_o
);
  import dda_pkg::*;

  // Slot phase codes
  localparam logic [1:0] PH_ACC   = 2'd0;
  localparam logic [1:0] PH_LOWER = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;

  logic                  active_q, active_d;
  logic [1:0]            phase_q, phase_d;
  logic [TIMER_BITS-1:0] dcnt_q, dcnt_d;
  logic [TIMER_BITS-1:0] dval_q, dval_d;
  logic [STEP_BITS-1:0]  cx_q, cx_d;
  logic [STEP_BITS-1:0]  cy_q, cy_d;
  logic [STEP_BITS-1:0]  major_q, major_d;
  logic [STEP_BITS-1:0]  slot_q, slot_d;
  logic [ACC_BITS-1:0]   accx_q, accx_d;
  logic [ACC_BITS-1:0]   accy_q, accy_d;
  logic                  negx_q, negx_d;
  logic                  negy_q, negy_d;
  logic                  track_q, track_d;
  logic [1:0]            pulse_q, pulse_d;
  logic [STEP_BITS-1:0]  absx_q, absx_d;
  logic [STEP_BITS-1:0]  relx_q, relx_d;
  logic [STEP_BITS-1:0]  rely_q, rely_d;
  logic [PEAK_BITS-1:0]  peak_q, peak_d;
  logic                  out_valid_q, out_valid_d;
  dda_out_t              out_q, out_d;

  logic                  go;
  logic                  done;
  logic [ACC_BITS-1:0]   sum_x, sum_y, major_ext;
  logic [STEP_BITS-1:0]  relx_step;
  logic [STEP_BITS-1:0]  slot_inc;

  // Step a position by one in the latched direction
  function automatic logic [STEP_BITS-1:0] bump(input logic [STEP_BITS-1:0] v,
                                                 input logic neg);
    logic [STEP_BITS-1:0] r;
    r = neg ? (v - {{(STEP_BITS-1){1'b0}}, 1'b1}) : (v + {{(STEP_BITS-1){1'b0}}, 1'b1});
    return r;
  endfunction

  // Take a command whenever the output register is free or being drained
  assign go          = pop_valid_i && !(out_valid_q && out_stall_i);
  assign pop_stall_o = out_valid_q && out_stall_i;

  assign major_ext = {1'b0, major_q};
  assign sum_x     = accx_q + {1'b0, cx_q};
  assign sum_y     = accy_q + {1'b0, cy_q};
  assign relx_step = bump(relx_q, negx_q);
  assign slot_inc  = slot_q + {{(STEP_BITS-1){1'b0}}, 1'b1};

  // Next state for the command at the head of the queue
  always_comb begin
    active_d = active_q;  phase_d = phase_q;  dcnt_d = dcnt_q;  dval_d = dval_q;
    cx_d     = cx_q;      cy_d    = cy_q;     major_d = major_q; slot_d = slot_q;
    accx_d   = accx_q;    accy_d  = accy_q;   negx_d = negx_q;   negy_d = negy_q;
    track_d  = track_q;   pulse_d = pulse_q;  absx_d = absx_q;   relx_d = relx_q;
    rely_d   = rely_q;    peak_d  = peak_q;
    done     = 1'b0;
    if (go) begin
      case (pop_cmd_i.kind)
        KIND_START: begin
          if (!active_q) begin
            cx_d    = pop_cmd_i.count_x;
            cy_d    = pop_cmd_i.count_y;
            negx_d  = pop_cmd_i.neg_x;
            negy_d  = pop_cmd_i.neg_y;
            major_d = pop_cmd_i.major;
            if (pop_cmd_i.major == '0) begin
              // zero-length move finishes at once without a slot
              done = 1'b1;
            end else begin
              if (pop_cmd_i.clear_error) begin
                accx_d = '0;
                accy_d = '0;
              end
              track_d  = pop_cmd_i.track_relative;
              dval_d   = pop_cmd_i.delay;
              dcnt_d   = '0;
              phase_d  = PH_ACC;
              slot_d   = '0;
              pulse_d  = 2'b00;
              active_d = 1'b1;
            end
          end
        end
        KIND_CLEAR: begin
          relx_d = '0;
          rely_d = '0;
          peak_d = '0;
        end
        KIND_TICK: begin
          if (active_q) begin
            if (dcnt_q >= dval_q) begin
              dcnt_d = '0;
              case (phase_q)
                PH_ACC: begin
                  accx_d = sum_x;
                  accy_d = sum_y;
                  if (sum_x >= major_ext) begin
                    pulse_d[0] = 1'b1;
                    accx_d     = sum_x - major_ext;
                    absx_d     = bump(absx_q, negx_q);
                    if (track_q) begin
                      relx_d = relx_step;
                      if (!relx_step[STEP_BITS-1] &&
                          (relx_step > {1'b0, peak_q})) begin
                        peak_d = relx_step[PEAK_BITS-1:0];
                      end
                    end
                  end
                  if (sum_y >= major_ext) begin
                    pulse_d[1] = 1'b1;
                    accy_d     = sum_y - major_ext;
                    if (track_q) begin
                      rely_d = bump(rely_q, negy_q);
                    end
                  end
                  phase_d = PH_LOWER;
                end
                PH_LOWER: begin
                  pulse_d = 2'b00;
                  phase_d = PH_COUNT;
                end
                default: begin
                  slot_d = slot_inc;
                  if (slot_inc >= major_q) begin
                    active_d = 1'b0;
                    done     = 1'b1;
                  end
                  phase_d = PH_ACC;
                end
              endcase
            end else begin
              dcnt_d = dcnt_q + {{(TIMER_BITS-1){1'b0}}, 1'b1};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Build the result from the updated state
  always_comb begin
    out_d.step_x    = pulse_d[0];
    out_d.step_y    = pulse_d[1];
    out_d.dir_x     = negx_d;
    out_d.dir_y     = !negy_d;
    out_d.busy_res  = active_d;
    out_d.done_res  = done;
    out_d.abs_x     = absx_d;
    out_d.rel_x     = relx_d;
    out_d.rel_y     = rely_d;
    out_d.max_rel_x = peak_d;
    out_valid_d     = go ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;  phase_q <= PH_ACC;  dcnt_q <= '0;  dval_q <= '0;
      cx_q     <= '0;    cy_q    <= '0;      major_q <= '0; slot_q <= '0;
      accx_q   <= '0;    accy_q  <= '0;      negx_q <= 1'b0; negy_q <= 1'b0;
      track_q  <= 1'b0;  pulse_q <= 2'b00;   absx_q <= '0;  relx_q <= '0;
      rely_q   <= '0;    peak_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;  phase_q <= phase_d;  dcnt_q <= dcnt_d;   dval_q <= dval_d;
      cx_q     <= cx_d;      cy_q    <= cy_d;     major_q <= major_d; slot_q <= slot_d;
      accx_q   <= accx_d;    accy_q  <= accy_d;   negx_q <= negx_d;   negy_q <= negy_d;
      track_q  <= track_d;   pulse_q <= pulse_d;  absx_q <= absx_d;   relx_q <= relx_d;
      rely_q   <= rely_d;    peak_q  <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`include "two_axis_dda_step_generator_defines.svh"

  `DDA_ASSERT(a_busy_major, clk_i, rst_ni, active_q |-> (major_q != '0), "move active with zero major count")
  `DDA_ASSERT(a_pulse_in_move, clk_i, rst_ni, (pulse_q != 2'b00) |-> active_q, "step pulse raised outside a move")
  `DDA_ASSERT(a_slot_bound, clk_i, rst_ni, active_q |-> (slot_q < major_q), "slot count reached major count in a move")

endmodule
`default_nettype wire

// ===== rtl/two_axis_dda_step_generator.sv =====
// Top level of the two-axis DDA step pulse generator.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one command per
//   transaction: a timer tick, a move start or a clear of the relative counters.
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns exactly one
//   result per input transaction, in order: pulse levels, directions, busy and
//   done flags, and the absolute and relative step positions after the update.
//   Results are registered: an accepted transaction is written into the queue
//   and then executed into the output register. Throughput: one transaction
//   per cycle while the receiver does not stall; the executor updates all move
//   state at once, so ticks from a free-running time base keep pace.
//   A two-entry command queue sits between decode and execution; when the
//   receiver stalls, the output register holds its result, the executor
//   pauses, the queue fills and in_stall_o rises once it holds two commands.
//   Reset (rst_ni low, asynchronous) clears the move, timer, accumulators,
//   positions and peak, and empties the queue and output register.
//   Each step slot runs three phases of (phase_delay + 1) ticks each.
`timescale 1ns / 1ps
`default_nettype none
module two_axis_dda_step_generator (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  dda_pkg::dda_in_t  in_item_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output dda_pkg::dda_out_t out_item_o
);
  import dda_pkg::*;

  logic     push_valid, push_stall;
  dda_cmd_t push_cmd;
  logic     pop_valid, pop_stall;
  dda_cmd_t pop_cmd;

  dda_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_stall_i (push_stall),
    .push_cmd_o   (push_cmd)
  );

  dda_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_stall_i  (pop_stall),
    .pop_cmd_o    (pop_cmd)
  );

  dda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_stall_o (pop_stall),
    .pop_cmd_i   (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the two-axis DDA step pulse generator.
`timescale 1ns / 1ps
module testbench;
  import dda_pkg::*;

  // Opcode with no meaning; the block must return a result and leave its state unchanged
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    STAGE_RAISE,
    STAGE_LOWER,
    STAGE_COUNT
  } stage_e;

  // One row of the directed table; pinned rows carry a hand-written result
  typedef struct {
    dda_in_t  cmd;
    bit       pinned;
    dda_out_t want;
  } step_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  dda_in_t  in_item_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  dda_out_t out_item_o;

  // Hold both sides busy while set
  bit       steady = 1'b0;
  int       mismatches = 0;
  dda_out_t expected_results[$];

  // Motion state mirrored by the predictor
  bit             running    = 1'b0;
  stage_e         stage      = STAGE_RAISE;
  logic [15:0]    tick_cnt   = '0;
  logic [15:0]    tick_limit = '0;
  logic [15:0]    len_x      = '0;
  logic [15:0]    len_y      = '0;
  logic [15:0]    span       = '0;
  logic [15:0]    slots_done = '0;
  logic [16:0]    err_x      = '0;
  logic [16:0]    err_y      = '0;
  bit             back_x     = 1'b0;
  bit             back_y     = 1'b0;
  bit             follow_rel = 1'b0;
  bit             pulse_x    = 1'b0;
  bit             pulse_y    = 1'b0;
  logic [15:0]    at_x       = '0;
  logic [15:0]    off_x      = '0;
  logic [15:0]    off_y      = '0;
  logic [14:0]    peak       = '0;

  two_axis_dda_step_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advance the motion state by one command and return the positions after it
  function automatic dda_out_t advance_motion(input dda_in_t cmd);
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    bit          done;
    dda_out_t    res;
    done  = 1'b0;
    raw_x = cmd.steps_x;
    raw_y = cmd.steps_y;
    if (cmd.op == OP_START && !running) begin
      mag_x  = raw_x[15] ? 16'(~raw_x + 16'd1) : raw_x;
      mag_y  = raw_y[15] ? 16'(~raw_y + 16'd1) : raw_y;
      len_x  = mag_x;
      len_y  = mag_y;
      back_x = raw_x[15];
      back_y = raw_y[15];
      span   = (mag_x > mag_y) ? mag_x : mag_y;
      if (span == '0) begin
        done = 1'b1;
      end else begin
        if (cmd.clear_error) begin
          err_x = '0;
          err_y = '0;
        end
        follow_rel = cmd.track_relative;
        tick_limit = cmd.phase_delay;
        tick_cnt   = '0;
        stage      = STAGE_RAISE;
        slots_done = '0;
        pulse_x    = 1'b0;
        pulse_y    = 1'b0;
        running    = 1'b1;
      end
    end else if (cmd.op == OP_CLEAR) begin
      off_x = '0;
      off_y = '0;
      peak  = '0;
    end else if (cmd.op == OP_TICK && running) begin
      if (tick_cnt >= tick_limit) begin
        tick_cnt = '0;
        case (stage)
          STAGE_RAISE: begin
            // Accumulate error and step each axis whose error reaches the span
            err_x = err_x + {1'b0, len_x};
            err_y = err_y + {1'b0, len_y};
            if (err_x >= {1'b0, span}) begin
              pulse_x = 1'b1;
              err_x   = err_x - {1'b0, span};
              at_x    = back_x ? at_x - 16'd1 : at_x + 16'd1;
              if (follow_rel) begin
                off_x = back_x ? off_x - 16'd1 : off_x + 16'd1;
                if (!off_x[15] && off_x[14:0] > peak) peak = off_x[14:0];
              end
            end
            if (err_y >= {1'b0, span}) begin
              pulse_y = 1'b1;
              err_y   = err_y - {1'b0, span};
              if (follow_rel) off_y = back_y ? off_y - 16'd1 : off_y + 16'd1;
            end
            stage = STAGE_LOWER;
          end
          STAGE_LOWER: begin
            pulse_x = 1'b0;
            pulse_y = 1'b0;
            stage   = STAGE_COUNT;
          end
          default: begin
            slots_done = slots_done + 16'd1;
            if (slots_done >= span) begin
              running = 1'b0;
              done    = 1'b1;
            end
            stage = STAGE_RAISE;
          end
        endcase
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
    end
    res.step_x    = pulse_x;
    res.step_y    = pulse_y;
    res.dir_x     = back_x;
    res.dir_y     = !back_y;
    res.busy_res  = running;
    res.done_res  = done;
    res.abs_x     = at_x;
    res.rel_x     = off_x;
    res.rel_y     = off_y;
    res.max_rel_x = peak;
    return res;
  endfunction

  function automatic dda_in_t cmd_of(logic [1:0] op, int sx, int sy, int dly, bit clr,
                                     bit trk);
    dda_in_t c;
    c.op             = op;
    c.steps_x        = 16'(sx);
    c.steps_y        = 16'(sy);
    c.phase_delay    = 16'(dly);
    c.clear_error    = clr;
    c.track_relative = trk;
    return c;
  endfunction

  // Result of an idle block straight out of reset
  function automatic dda_out_t at_rest(bit done);
    dda_out_t r;
    r          = '0;
    r.dir_y    = 1'b1;
    r.done_res = done;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < 40)
      $display("tb: mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_result(input dda_out_t got);
    dda_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", '0, '0);
      return;
    end
    want = expected_results.pop_front();
    if (got.step_x !== want.step_x)
      report_mismatch("step_x", 16'(got.step_x), 16'(want.step_x));
    if (got.step_y !== want.step_y)
      report_mismatch("step_y", 16'(got.step_y), 16'(want.step_y));
    if (got.dir_x !== want.dir_x)
      report_mismatch("dir_x", 16'(got.dir_x), 16'(want.dir_x));
    if (got.dir_y !== want.dir_y)
      report_mismatch("dir_y", 16'(got.dir_y), 16'(want.dir_y));
    if (got.busy_res !== want.busy_res)
      report_mismatch("busy_res", 16'(got.busy_res), 16'(want.busy_res));
    if (got.done_res !== want.done_res)
      report_mismatch("done_res", 16'(got.done_res), 16'(want.done_res));
    if (got.abs_x !== want.abs_x) report_mismatch("abs_x", got.abs_x, want.abs_x);
    if (got.rel_x !== want.rel_x) report_mismatch("rel_x", got.rel_x, want.rel_x);
    if (got.rel_y !== want.rel_y) report_mismatch("rel_y", got.rel_y, want.rel_y);
    if (got.max_rel_x !== want.max_rel_x)
      report_mismatch("max_rel_x", 16'(got.max_rel_x), 16'(want.max_rel_x));
  endtask

  // Offer one command, hold it until accepted, then queue its expected result
  task automatic send_cmd(input dda_in_t cmd, input bit pinned, input dda_out_t want);
    dda_out_t predicted;
    while (!steady && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_motion(cmd);
    expected_results.push_back(pinned ? want : predicted);
  endtask

  // Hold off the sender until every expected result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Start a move and tick it through to the end
  task automatic run_move(input int sx, input int sy, input int dly, input bit trk);
    send_cmd(cmd_of(OP_START, sx, sy, dly, 1'b0, trk), 1'b0, '0);
    while (running) send_cmd(cmd_of(OP_TICK, 0, 0, 0, 1'b0, 1'b0), 1'b0, '0);
  endtask

  // Receiver: check accepted results and stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result(out_item_o);
      out_stall_i <= !steady && ($urandom_range(99) < 36);
    end
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    step_row_t steps_table[$];
    dda_in_t   cmd;
    int        counted;
    int        pick;
    int        lim;
    int        mx;
    int        my;

    // Directed table: idle corners, ignored commands, then two short moves
    steps_table.push_back('{cmd_of(OP_TICK, 0, 0, 0, 1'b0, 1'b0), 1'b1, at_rest(1'b0)});
    steps_table.push_back('{cmd_of(OP_UNUSED, -1, -1, 16'hFFFF, 1'b1, 1'b1), 1'b1,
                            at_rest(1'b0)});
    steps_table.push_back('{cmd_of(OP_CLEAR, 0, 0, 0, 1'b0, 1'b0), 1'b1, at_rest(1'b0)});
    steps_table.push_back('{cmd_of(OP_START, 0, 0, 5, 1'b1, 1'b1), 1'b1, at_rest(1'b1)});
    steps_table.push_back('{cmd_of(OP_START, 2, -1, 0, 1'b1, 1'b1), 1'b0, '0});
    steps_table.push_back('{cmd_of(OP_TICK, 0, 0, 0, 1'b0, 1'b0), 1'b0, '0});
    steps_table.push_back('{cmd_of(OP_START, -32768, 32767, 16'hFFFF, 1'b1, 1'b1), 1'b0, '0});
    steps_table.push_back('{cmd_of(OP_TICK, 0, 0, 0, 1'b0, 1'b0), 1'b0, '0});
    steps_table.push_back('{cmd_of(OP_UNUSED, 0, 0, 0, 1'b0, 1'b0), 1'b0, '0});
    steps_table.push_back('{cmd_of(OP_TICK, 0, 0, 0, 1'b0, 1'b0), 1'b0, '0});
    steps_table.push_back('{cmd_of(OP_CLEAR, 0, 0, 0, 1'b0, 1'b0), 1'b0, '0});
    for (int i = 0; i < 3; i++)
      steps_table.push_back('{cmd_of(OP_TICK, 0, 0, 0, 1'b0, 1'b0), 1'b0, '0});
    steps_table.push_back('{cmd_of(OP_START, -1, 0, 1, 1'b0, 1'b1), 1'b0, '0});
    steps_table.push_back('{cmd_of(OP_START, 32767, -32768, 0, 1'b0, 1'b0), 1'b0, '0});
    for (int i = 0; i < 6; i++)
      steps_table.push_back('{cmd_of(OP_TICK, 0, 0, 0, 1'b0, 1'b0), 1'b0, '0});
    steps_table.push_back('{cmd_of(OP_START, 0, 0, 0, 1'b1, 1'b1), 1'b0, '0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps_table[i])
      send_cmd(steps_table[i].cmd, steps_table[i].pinned, steps_table[i].want);
    wait_drained();

    // Random part: mostly well-formed moves, with noise and ignored starts
    counted = 0;
    while (counted < 600) begin
      steady = (counted >= 200 && counted < 320);
      cmd    = dda_in_t'($bits(dda_in_t)'({$urandom, $urandom}));
      pick   = $urandom_range(99);
      if (running) begin
        if (pick < 80) cmd.op = OP_TICK;
        else if (pick < 87) cmd.op = OP_CLEAR;
        else if (pick < 92) cmd.op = OP_UNUSED;
        else cmd.op = OP_START;
      end else if (pick < 4) begin
        cmd.op = OP_UNUSED;
      end else if (pick < 8) begin
        cmd.op = OP_CLEAR;
      end else if (pick < 12) begin
        cmd.op = OP_TICK;
      end else begin
        pick = $urandom_range(99);
        lim  = (pick < 60) ? 4 : (pick < 90) ? 15 : 60;
        mx   = $urandom_range(lim);
        my   = $urandom_range(lim);
        if ($urandom_range(1)) mx = -mx;
        if ($urandom_range(1)) my = -my;
        pick = $urandom_range(99);
        cmd.op          = OP_START;
        cmd.steps_x     = 16'(mx);
        cmd.steps_y     = 16'(my);
        cmd.phase_delay = (pick < 60) ? 16'd0 :
                          (pick < 90) ? 16'($urandom_range(2, 1)) :
                                        16'($urandom_range(6, 3));
      end
      if ((cmd.op == OP_TICK && running) || (cmd.op == OP_START && !running) ||
          cmd.op == OP_CLEAR)
        counted++;
      send_cmd(cmd, 1'b0, '0);
    end
    steady = 1'b0;
    wait_drained();

    // Closing moves: fresh error, carried-over error, then a clear in between
    send_cmd(cmd_of(OP_START, 25, -18, 0, 1'b1, 1'b1), 1'b0, '0);
    while (running) send_cmd(cmd_of(OP_TICK, 0, 0, 0, 1'b0, 1'b0), 1'b0, '0);
    run_move(1, 0, 0, 1'b1);
    send_cmd(cmd_of(OP_CLEAR, 0, 0, 0, 1'b0, 1'b0), 1'b0, '0);
    run_move(-2, 3, 1, 1'b1);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dda_pkg.sv
rtl/dda_front.sv
rtl/dda_queue.sv
rtl/dda_back.sv
rtl/two_axis_dda_step_generator.sv
tb/sv/testbench.sv
